### design/directory_entry_search_defines.svh
// ---------------------------------------------------------------------------
// Directory entry search: assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef DIRECTORY_ENTRY_SEARCH_DEFINES_SVH
`define DIRECTORY_ENTRY_SEARCH_DEFINES_SVH

// same-cycle implication
`define DES_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("directory entry search assertion failed");

// next-cycle implication
`define DES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("directory entry search assertion failed");

`endif

### design/des_pkg.sv
// ---------------------------------------------------------------------------
// Directory entry search package
// Word types, status codes, register indexes and entry layout constants.
// ---------------------------------------------------------------------------
package des_pkg;

    localparam int ENTRY_BYTES = 32;
    localparam int NAME_BYTES  = 11;
    localparam int NAME_BITS   = 8 * NAME_BYTES;
    localparam int OFF_W       = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [4:0] ATTR_INDEX = 5'd11;

    localparam logic [7:0] MARK_END       = 8'h00;
    localparam logic [7:0] MARK_DELETED   = 8'hE5;
    localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;
    localparam logic [7:0] ATTR_LABEL_BIT = 8'h08;

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_FREE  = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NAME_FIRST_EIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_LAST_THREE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_SLOT_MODE   = 2'd2;

    typedef struct packed {
        logic [7:0]  entry_byte;
        logic [31:0] sector_address;
        logic        end_of_directory;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       status;
        logic [31:0]      slot_sector;
        logic [OFF_W-1:0] slot_offset;
    } t_out_word;

endpackage

### design/directory_entry_search.sv
// ---------------------------------------------------------------------------
// Directory entry search
// Scans a stream of directory bytes for a short name or a free slot.
// ---------------------------------------------------------------------------
// One directory byte is accepted per clock, back to back, while no end word
// is held back. The one result of a directory is registered and shows on
// the output in the cycle after its end word is accepted. Bytes that end
// no directory are taken even while a result waits; an end word waits only
// while the output register is full and stalled.
module directory_entry_search #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [des_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [des_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  des_pkg::t_in_word                   i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output des_pkg::t_out_word                  o_out_word
);
    import des_pkg::*;

    logic [63:0]        r_name_first_eight;
    logic [23:0]        r_name_last_three;
    logic               r_free_mode;
    logic               r_out_valid;
    t_out_word          r_out;
    t_out_word          result;
    logic               take;

    assign o_in_ready  = !r_out_valid || i_out_ready || !i_in_word.end_of_directory;
    assign take        = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_first_eight <= '0;
            r_name_last_three  <= '0;
            r_free_mode        <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NAME_FIRST_EIGHT: r_name_first_eight <= i_cfg_data;
                CFG_NAME_LAST_THREE:  r_name_last_three  <= i_cfg_data[23:0];
                CFG_FREE_SLOT_MODE:   r_free_mode        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    des_scan #(
        .SECTOR_BYTES(SECTOR_BYTES)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_word      (i_in_word),
        .i_name      ({r_name_last_three, r_name_first_eight}),
        .i_free_mode (r_free_mode),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && i_in_word.end_of_directory) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_in_word.end_of_directory) begin
            r_out <= result;
        end
    end

endmodule

### design/des_scan.sv
// ---------------------------------------------------------------------------
// Directory entry search: scan state
// Per-byte entry parsing, name compare and match / free slot tracking.
// ---------------------------------------------------------------------------
module des_scan #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_take,
    input  des_pkg::t_in_word         i_word,
    input  logic [des_pkg::NAME_BITS-1:0] i_name,
    input  logic                      i_free_mode,
    output des_pkg::t_out_word        o_result
);
    import des_pkg::*;

    localparam int POS_W = $clog2(SECTOR_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(SECTOR_BYTES - 1);

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_name_eq, n_name_eq;
    logic             r_free, n_free;
    logic             r_stopped, n_stopped;
    logic             r_match_seen, n_match_seen;
    logic [31:0]      r_match_sector, n_match_sector;
    logic [OFF_W-1:0] r_match_off, n_match_off;
    logic             r_free_seen, n_free_seen;
    logic [31:0]      r_free_sector, n_free_sector;
    logic [OFF_W-1:0] r_free_off, n_free_off;

    logic [7:0]         want [16];
    logic [4:0]         idx;
    logic [POS_W-1:0]   ent_pos;
    logic [POS_W+OFF_W-1:0] off_ext;
    logic [OFF_W-1:0]   ent_off;
    logic [7:0]         b;
    logic               is_free;
    logic               skip;

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            if (k < NAME_BYTES) begin
                want[k] = i_name[8*k +: 8];
            end else begin
                want[k] = 8'h00;
            end
        end
    end

    assign idx     = r_pos[4:0];
    assign ent_pos = {r_pos[POS_W-1:5], 5'b0};
    assign off_ext = {{OFF_W{1'b0}}, ent_pos};
    assign ent_off = off_ext[OFF_W-1:0];
    assign b       = i_word.entry_byte;
    assign is_free = (b == MARK_END) || (b == MARK_DELETED);
    assign skip    = r_free || (b == ATTR_LONG_NAME) || ((b & ATTR_LABEL_BIT) != 8'h00);

    always_comb begin
        n_pos          = (r_pos == POS_LAST) ? '0 : r_pos + POS_W'(1);
        n_name_eq      = r_name_eq;
        n_free         = r_free;
        n_stopped      = r_stopped;
        n_match_seen   = r_match_seen;
        n_match_sector = r_match_sector;
        n_match_off    = r_match_off;
        n_free_seen    = r_free_seen;
        n_free_sector  = r_free_sector;
        n_free_off     = r_free_off;

        if (!r_stopped) begin
            if (idx == 5'd0) begin
                n_free    = is_free;
                n_name_eq = (b == want[0]);
                if (is_free && !r_free_seen) begin
                    n_free_seen   = 1'b1;
                    n_free_sector = i_word.sector_address;
                    n_free_off    = ent_off;
                end
                if (b == MARK_END) begin
                    n_stopped = 1'b1;
                end
            end else if (idx < ATTR_INDEX) begin
                n_name_eq = r_name_eq && (b == want[idx[3:0]]);
            end else if (idx == ATTR_INDEX) begin
                if (!skip && r_name_eq) begin
                    n_match_seen   = 1'b1;
                    n_match_sector = i_word.sector_address;
                    n_match_off    = ent_off;
                    n_stopped      = 1'b1;
                end
            end
        end

        if (n_match_seen) begin
            o_result.status      = ST_FOUND;
            o_result.slot_sector = n_match_sector;
            o_result.slot_offset = n_match_off;
        end else if (i_free_mode && n_free_seen) begin
            o_result.status      = ST_FREE;
            o_result.slot_sector = n_free_sector;
            o_result.slot_offset = n_free_off;
        end else begin
            o_result.status      = ST_NONE;
            o_result.slot_sector = '0;
            o_result.slot_offset = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_name_eq    <= 1'b1;
            r_free       <= 1'b0;
            r_stopped    <= 1'b0;
            r_match_seen <= 1'b0;
            r_free_seen  <= 1'b0;
        end else if (i_take) begin
            if (i_word.end_of_directory) begin
                r_pos        <= '0;
                r_name_eq    <= 1'b1;
                r_free       <= 1'b0;
                r_stopped    <= 1'b0;
                r_match_seen <= 1'b0;
                r_free_seen  <= 1'b0;
            end else begin
                r_pos        <= n_pos;
                r_name_eq    <= n_name_eq;
                r_free       <= n_free;
                r_stopped    <= n_stopped;
                r_match_seen <= n_match_seen;
                r_free_seen  <= n_free_seen;
            end
        end
    end

    // slot payload is qualified by the seen flags
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_match_sector <= n_match_sector;
            r_match_off    <= n_match_off;
            r_free_sector  <= n_free_sector;
            r_free_off     <= n_free_off;
        end
    end

endmodule

### design/des_checker.sv
// ---------------------------------------------------------------------------
// Directory entry search checker
// Port-level properties of the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "directory_entry_search_defines.svh"

module des_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_ready,
    input  des_pkg::t_in_word    i_in_word,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  des_pkg::t_out_word   o_out_word
);
    import des_pkg::*;

    logic end_take;
    logic slot_free;

    assign end_take  = i_in_valid && o_in_ready && i_in_word.end_of_directory;
    assign slot_free = !o_out_valid || i_out_ready;

    `DES_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_word))
    `DES_ASSERT_NEXT(a_result_follows_end, i_clk, i_rst_n, end_take, o_out_valid)
    `DES_ASSERT_NEXT(a_no_spurious_result, i_clk, i_rst_n, slot_free && !end_take, !o_out_valid)
    `DES_ASSERT_NOW(a_none_zero_slot, i_clk, i_rst_n, o_out_valid && o_out_word.status == ST_NONE, o_out_word.slot_sector == 32'd0 && o_out_word.slot_offset == '0)
    `DES_ASSERT_NOW(a_offset_aligned, i_clk, i_rst_n, o_out_valid, o_out_word.slot_offset[4:0] == 5'd0)

endmodule

bind directory_entry_search des_checker u_des_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
